FILE: design/qtg_pkg.sv
// Shared constants of the quintic trajectory generator.
// Depends on nothing; qtg_if, qtg_poly and the top level import it.
package qtg_pkg;

  // fixed field widths
  localparam int TIME_W   = 24;
  localparam int DUR_W    = 20;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W = 2;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_BEFORE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MOVE   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_AFTER  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd2;

endpackage

FILE: design/qtg_if.sv
// Valid/ready channel interfaces of the trajectory generator.
// Depends on qtg_pkg for the fixed field widths.

interface qtg_in_if;
  import qtg_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_tick;
  modport source (output valid, output time_tick, input ready);
  modport sink   (input valid, input time_tick, output ready);
endinterface

interface qtg_out_if #(parameter int POS_WIDTH = 32);
  import qtg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_WIDTH-1:0] position;
  logic [POS_WIDTH-1:0] velocity;
  logic [POS_WIDTH-1:0] acceleration;
  logic [PHASE_W-1:0]   phase;
  modport source (output valid, output position, output velocity, output acceleration,
                  output phase, input ready);
  modport sink   (input valid, input position, input velocity, input acceleration,
                  input phase, output ready);
endinterface

interface qtg_cfg_if #(parameter int DATA_WIDTH = 32);
  import qtg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [DATA_WIDTH-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/qtg_div.sv
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
// Depends on nothing; used for tau = t/T and for the divisions by T.
module qtg_div #(
  parameter int NUM_W  = 24,
  parameter int DEN_W  = 20,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [DEN_W-1:0]  rem0,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W-1:0]  vld;
  logic [DEN_W-1:0]  rem  [NUM_W];
  logic [NUM_W-1:0]  acc  [NUM_W];
  logic [SIDE_W-1:0] side [NUM_W];
  logic [DEN_W-1:0]  rem_next [NUM_W];
  logic [NUM_W-1:0]  acc_next [NUM_W];

  // one compare-subtract per stage; acc shifts numerator out, quotient in
  always_comb begin
    logic [DEN_W-1:0] pr;
    logic [NUM_W-1:0] pa;
    logic [DEN_W:0]   tr;
    logic             qb;
    for (int k = 0; k < NUM_W; k++) begin
      pr = (k == 0) ? rem0 : rem[(k == 0) ? 0 : k-1];
      pa = (k == 0) ? num  : acc[(k == 0) ? 0 : k-1];
      tr = {pr, pa[NUM_W-1]};
      qb = (tr >= {1'b0, den});
      rem_next[k] = qb ? DEN_W'(tr - {1'b0, den}) : tr[DEN_W-1:0];
      acc_next[k] = {pa[NUM_W-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_W-2:0], in_valid};
    end
    if (en) begin
      for (int k = 0; k < NUM_W; k++) begin
        rem[k]  <= rem_next[k];
        acc[k]  <= acc_next[k];
        side[k] <= (k == 0) ? side_in : side[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quot      = acc[NUM_W-1];
  assign side_out  = side[NUM_W-1];

endmodule

FILE: design/qtg_poly.sv
// Five-stage polynomial datapath: shape factors of position, velocity and
// acceleration from tau, scaled by |end - start|. Depends on qtg_pkg.
module qtg_poly #(
  parameter int POS_W = 32,
  parameter int F     = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [F:0]                  tau,
  input  logic [qtg_pkg::PHASE_W-1:0] phase_in,
  input  logic [POS_W-1:0]            start_pos,
  input  logic [POS_W-1:0]            end_pos,
  output logic                        out_valid,
  output logic [qtg_pkg::PHASE_W-1:0] phase_out,
  output logic [POS_W-1:0]            position,
  output logic [POS_W+5:0]            vnum,
  output logic [POS_W+5:0]            anum,
  output logic                        negv,
  output logic                        nega
);
  import qtg_pkg::*;

  localparam int TW = F + 1;          // Q1.F up to and including 1.0
  localparam int KW = F + 6;          // scaled factors below 64.0
  localparam int AW = POS_W + 1;      // |end - start|
  localparam int VN = POS_W + 6;
  localparam logic [TW-1:0] ONE = TW'(1) << F;
  localparam int K10 = 10;
  localparam int K15 = 15;
  localparam int K6  = 6;
  localparam int K30 = 30;
  localparam int K60 = 60;

  // stage 1: squares, 1 - tau, |1 - 2 tau|, distance
  logic [TW-1:0]   u;
  logic [2*TW-1:0] p_tt, p_uu, p_tu;
  logic [TW:0]     tau_x2;
  logic [AW-1:0]   delta;
  logic            v1, cneg1, neg1;
  logic [PHASE_W-1:0] ph1;
  logic [TW-1:0]   tau1, tau2_1, uu1, w1, cm1;
  logic [KW-1:0]   posb1;
  logic [AW-1:0]   ad1;

  assign u      = ONE - tau;
  assign p_tt   = (2*TW)'(tau) * (2*TW)'(tau);
  assign p_uu   = (2*TW)'(u) * (2*TW)'(u);
  assign p_tu   = (2*TW)'(tau) * (2*TW)'(u);
  assign tau_x2 = {tau, 1'b0};
  assign delta  = {end_pos[POS_W-1], end_pos} - {start_pos[POS_W-1], start_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ph1    <= phase_in;
      tau1   <= tau;
      tau2_1 <= p_tt[F +: TW];
      uu1    <= p_uu[F +: TW];
      w1     <= p_tu[F +: TW];
      cneg1  <= (tau_x2 > {1'b0, ONE});
      cm1    <= (tau_x2 > {1'b0, ONE}) ? TW'(tau_x2 - {1'b0, ONE})
                                       : TW'({1'b0, ONE} - tau_x2);
      posb1  <= KW'(tau) * KW'(K15);
      neg1   <= delta[AW-1];
      ad1    <= delta[AW-1] ? AW'(-delta) : delta;
    end
  end

  // stage 2: tau^3, tau^2 (1-tau)^2, 60 tau (1-tau) |1-2tau|, 10 - 15 tau + 6 tau^2
  logic [2*TW-1:0] p_t3, p_gi, p_wc;
  logic [KW-1:0]   posa;
  logic            v2, cneg2, neg2;
  logic [PHASE_W-1:0] ph2;
  logic [TW-1:0]   tau3_2, gi2;
  logic [KW-1:0]   hm2, diff2;
  logic [AW-1:0]   ad2;

  assign p_t3 = (2*TW)'(tau2_1) * (2*TW)'(tau1);
  assign p_gi = (2*TW)'(tau2_1) * (2*TW)'(uu1);
  assign p_wc = (2*TW)'(w1) * (2*TW)'(cm1);
  assign posa = KW'(ONE) * KW'(K10) + KW'(tau2_1) * KW'(K6);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      ph2    <= ph1;
      tau3_2 <= p_t3[F +: TW];
      gi2    <= p_gi[F +: TW];
      hm2    <= KW'(p_wc[F +: TW]) * KW'(K60);
      diff2  <= (posa >= posb1) ? posa - posb1 : '0;
      cneg2  <= cneg1;
      neg2   <= neg1;
      ad2    <= ad1;
    end
  end

  // stage 3: position shape factor, clamped to 1.0; velocity factor
  logic [TW+KW-1:0] p_s;
  logic [KW-1:0]    s_raw;
  logic             v3, cneg3, neg3;
  logic [PHASE_W-1:0] ph3;
  logic [TW-1:0]    s3;
  logic [KW-1:0]    g3, hm3;
  logic [AW-1:0]    ad3;

  assign p_s   = (TW+KW)'(tau3_2) * (TW+KW)'(diff2);
  assign s_raw = p_s[F +: KW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      ph3   <= ph2;
      s3    <= (s_raw > KW'(ONE)) ? ONE : s_raw[TW-1:0];
      g3    <= KW'(gi2) * KW'(K30);
      hm3   <= hm2;
      cneg3 <= cneg2;
      neg3  <= neg2;
      ad3   <= ad2;
    end
  end

  // stage 4: scale all three factors by the distance
  logic [AW+TW-1:0] p_pm;
  logic [AW+KW-1:0] p_vn, p_an;
  logic             v4, cneg4, neg4;
  logic [PHASE_W-1:0] ph4;
  logic [AW-1:0]    pm4;
  logic [VN-1:0]    vn4, an4;

  assign p_pm = (AW+TW)'(ad3) * (AW+TW)'(s3);
  assign p_vn = (AW+KW)'(ad3) * (AW+KW)'(g3);
  assign p_an = (AW+KW)'(ad3) * (AW+KW)'(hm3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      ph4   <= ph3;
      pm4   <= p_pm[F +: AW];
      vn4   <= p_vn[F +: VN];
      an4   <= p_an[F +: VN];
      cneg4 <= cneg3;
      neg4  <= neg3;
    end
  end

  // stage 5: position = start +/- magnitude, wraps to the field width
  logic [AW-1:0] psum;
  logic          v5;

  assign psum = neg4 ? ({start_pos[POS_W-1], start_pos} - pm4)
                     : ({start_pos[POS_W-1], start_pos} + pm4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      phase_out <= ph4;
      position  <= psum[POS_W-1:0];
      vnum      <= vn4;
      anum      <= an4;
      negv      <= neg4;
      nega      <= neg4 ^ cneg4;
    end
  end

  assign out_valid = v5;

endmodule

FILE: design/quintic_trajectory_generator.sv
// Quintic (minimum-jerk) one-axis trajectory generator, top level.
// Depends on qtg_pkg, qtg_if, qtg_div and qtg_poly.
//
// Usage:
//   cfg    : register writes (index 0 start, 1 end, 2 duration in ticks), always
//            ready; write only while no item is in flight.
//   sample : one time_tick per item, signed ticks since the start of the move.
//   result : position, velocity, acceleration and phase for each item, in order.
// The pipeline holds an input stage, the bit-per-stage dividers (one for
// tau = t/T, one for velocity / T, and two chained for acceleration / T^2),
// the polynomial datapath and an output register.
// Throughput is one item per cycle while result is not stalled.
// The whole pipeline advances together; when result is stalled with a finished
// item waiting, sample.ready drops and nothing in flight is lost or repeated.
// Synchronous reset empties the pipeline and loads start = end = 0, duration 1.
module quintic_trajectory_generator #(
  parameter int POS_WIDTH     = 32,
  parameter int TAU_FRAC_BITS = 24
) (
  input logic         clk,
  input logic         rst,
  qtg_in_if.sink      sample,
  qtg_out_if.source   result,
  qtg_cfg_if.sink     cfg
);
  import qtg_pkg::*;

  localparam int F  = TAU_FRAC_BITS;
  localparam int VN = POS_WIDTH + 6;

  // configuration registers
  logic [POS_WIDTH-1:0] start_position;
  logic [POS_WIDTH-1:0] end_position;
  logic [DUR_W-1:0]     duration_ticks;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= '0;
      end_position   <= '0;
      duration_ticks <= DUR_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START:    start_position <= cfg.data[POS_WIDTH-1:0];
        REG_END:      end_position   <= cfg.data[POS_WIDTH-1:0];
        REG_DURATION: duration_ticks <= cfg.data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: stall only when a finished item waits at the output
  logic en;
  logic out_v;
  assign en           = !out_v || result.ready;
  assign sample.ready = en;

  logic [DUR_W-1:0] dur;
  assign dur = (duration_ticks == '0) ? DUR_W'(1) : duration_ticks;

  // input stage: classify the time sample
  logic               tneg, tgt, teq;
  logic               v0, q0;
  logic [PHASE_W-1:0] ph0;
  logic [DUR_W-1:0]   tq0;

  assign tneg = sample.time_tick[TIME_W-1];
  assign tgt  = !tneg && (sample.time_tick[TIME_W-2:0] > (TIME_W-1)'(dur));
  assign teq  = (sample.time_tick == TIME_W'(dur));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= sample.valid;
    end
    if (en) begin
      ph0 <= tneg ? PH_BEFORE : (tgt ? PH_AFTER : PH_MOVE);
      q0  <= teq;
      tq0 <= teq ? '0 : sample.time_tick[DUR_W-1:0];
    end
  end

  // tau fraction: (t << F) / T, integer bit already known
  logic                 tv;
  logic [F-1:0]         tfrac;
  logic [PHASE_W:0]     tside;

  qtg_div #(.NUM_W(F), .DEN_W(DUR_W), .SIDE_W(PHASE_W + 1)) u_tau_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .num       ('0),
    .den       (dur),
    .rem0      (tq0),
    .side_in   ({ph0, q0}),
    .out_valid (tv),
    .quot      (tfrac),
    .side_out  (tside)
  );

  // polynomial datapath
  logic                 pv, negv, nega;
  logic [PHASE_W-1:0]   pph;
  logic [POS_WIDTH-1:0] ppos;
  logic [VN-1:0]        vnum, anum;

  qtg_poly #(.POS_W(POS_WIDTH), .F(F)) u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tv),
    .tau       ({tside[0], tfrac}),
    .phase_in  (tside[PHASE_W:1]),
    .start_pos (start_position),
    .end_pos   (end_position),
    .out_valid (pv),
    .phase_out (pph),
    .position  (ppos),
    .vnum      (vnum),
    .anum      (anum),
    .negv      (negv),
    .nega      (nega)
  );

  // velocity / T alongside the first step of acceleration / T^2
  localparam int VSIDE_W = PHASE_W + POS_WIDTH + 1;
  logic               vv, av1;
  logic [VN-1:0]      vq, aq1;
  logic [VSIDE_W-1:0] vside;
  logic               aside;

  qtg_div #(.NUM_W(VN), .DEN_W(DUR_W), .SIDE_W(VSIDE_W)) u_vel_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pv),
    .num       (vnum),
    .den       (dur),
    .rem0      ('0),
    .side_in   ({pph, ppos, negv}),
    .out_valid (vv),
    .quot      (vq),
    .side_out  (vside)
  );

  qtg_div #(.NUM_W(VN), .DEN_W(DUR_W), .SIDE_W(1)) u_acc_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pv),
    .num       (anum),
    .den       (dur),
    .rem0      ('0),
    .side_in   (nega),
    .out_valid (av1),
    .quot      (aq1),
    .side_out  (aside)
  );

  // second division by T; floor(floor(x/T)/T) = floor(x/T^2)
  localparam int ASIDE_W = VSIDE_W + VN + 1;
  logic               av2;
  logic [VN-1:0]      aq2;
  logic [ASIDE_W-1:0] fside;

  qtg_div #(.NUM_W(VN), .DEN_W(DUR_W), .SIDE_W(ASIDE_W)) u_acc_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vv && av1),
    .num       (aq1),
    .den       (dur),
    .rem0      ('0),
    .side_in   ({vside, vq, aside}),
    .out_valid (av2),
    .quot      (aq2),
    .side_out  (fside)
  );

  // saturate a sign/magnitude pair to the signed output range
  function automatic logic [POS_WIDTH-1:0] sat_mag(input logic neg, input logic [VN-1:0] mag);
    logic [VN-1:0] lim;
    logic [VN-1:0] nm;
    lim = VN'(1) << (POS_WIDTH - 1);
    nm  = -mag;
    if (neg) begin
      return (mag >= lim) ? {1'b1, {(POS_WIDTH-1){1'b0}}} : nm[POS_WIDTH-1:0];
    end
    return (mag > lim - VN'(1)) ? {1'b0, {(POS_WIDTH-1){1'b1}}} : mag[POS_WIDTH-1:0];
  endfunction

  logic [PHASE_W-1:0]   fph;
  logic [POS_WIDTH-1:0] fpos;
  logic                 fnegv, fnega;
  logic [VN-1:0]        fvq;

  assign fnega = fside[0];
  assign fvq   = fside[VN:1];
  assign fnegv = fside[VN+1];
  assign fpos  = fside[VN+2 +: POS_WIDTH];
  assign fph   = fside[ASIDE_W-1 -: PHASE_W];

  // output register
  logic [POS_WIDTH-1:0] out_pos, out_vel, out_acc;
  logic [PHASE_W-1:0]   out_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= av2;
    end
    if (en) begin
      out_ph <= fph;
      case (fph)
        PH_MOVE: begin
          out_pos <= fpos;
          out_vel <= sat_mag(fnegv, fvq);
          out_acc <= sat_mag(fnega, aq2);
        end
        PH_AFTER: begin
          out_pos <= end_position;
          out_vel <= '0;
          out_acc <= '0;
        end
        default: begin
          out_pos <= start_position;
          out_vel <= '0;
          out_acc <= '0;
        end
      endcase
    end
  end

  assign result.valid        = out_v;
  assign result.position     = out_pos;
  assign result.velocity     = out_vel;
  assign result.acceleration = out_acc;
  assign result.phase        = out_ph;

endmodule
